FILE: rtl/core/tnvs_pkg.sv
// Package for the transformed nearest vertex search.
// Holds register codes, reset values and fixed widths; no dependencies.
package tnvs_pkg;

  // Transform row packing: three Q1.14 coefficients, then the translation.
  localparam int COEF_WIDTH = 16;
  localparam int COEF_FRAC  = 14;
  localparam int CFG_WIDTH  = 64;
  localparam int REF_WIDTH  = 48;

  // Squared distance result.
  localparam int SQ_WIDTH = 36;
  localparam logic [SQ_WIDTH-1:0] SQ_MAX = {SQ_WIDTH{1'b1}};

  // Configuration register indexes.
  localparam int CFG_IDX_WIDTH = 3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_X     = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_Y     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ROW_Z     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_REF_POINT = 3'd3;

  // Reset values: identity rotation, zero translation, origin reference.
  localparam logic [CFG_WIDTH-1:0] ROW_X_RESET = 64'h0000_0000_0000_4000;
  localparam logic [CFG_WIDTH-1:0] ROW_Y_RESET = 64'h0000_0000_4000_0000;
  localparam logic [CFG_WIDTH-1:0] ROW_Z_RESET = 64'h0000_4000_0000_0000;
  localparam logic [REF_WIDTH-1:0] REF_RESET   = '0;

  // Queue between the front pipeline and the minimum tracker.
  localparam int QUEUE_AW    = 3;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

FILE: rtl/core/tnvs_front.sv
// Front pipeline: configuration registers, rigid transform, rounding,
// saturation and squared distance. Depends on tnvs_pkg.
module tnvs_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tnvs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [tnvs_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_z,
  input  logic                               in_last_vertex,
  input  logic                               slot_free,
  output logic                               push,
  output logic [3*COORD_WIDTH+tnvs_pkg::SQ_WIDTH:0] push_data
);
  import tnvs_pkg::*;

  localparam int PRW   = COORD_WIDTH + COEF_WIDTH;
  localparam int ACC_W = COORD_WIDTH + 20;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int SQW   = 2 * DW;
  localparam int SUMW  = (SQW + 2 > SQ_WIDTH) ? SQW + 2 : SQ_WIDTH + 1;
  localparam int REFX_W = (3 * COORD_WIDTH > REF_WIDTH) ? 3 * COORD_WIDTH : REF_WIDTH;
  localparam int CRW   = QUEUE_AW + 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] P_HI =
    {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] P_LO =
    {{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic [CFG_WIDTH-1:0] row_r [3];
  logic [REF_WIDTH-1:0] ref_r;
  logic [REFX_W-1:0]    ref_ext;

  logic [CRW-1:0] credit_r, credit_nxt;
  logic           in_acc;

  logic                          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                          last1_r, last2_r, last3_r, last4_r, last5_r;
  logic signed [PRW-1:0]         prod1_r [3][3];
  logic signed [COEF_WIDTH-1:0]  trans1_r [3];
  logic signed [ACC_W-1:0]       acc2_r [3];
  logic signed [COORD_WIDTH-1:0] p3_r [3];
  logic signed [COORD_WIDTH-1:0] p4_r [3];
  logic [SQW-1:0]                sq4_r [3];
  logic [COORD_WIDTH-1:0]        p5_r [3];
  logic [SQ_WIDTH-1:0]           sq5_r;

  logic signed [COORD_WIDTH-1:0] vtx [3];
  logic signed [PRW-1:0]         prod1_nxt [3][3];
  logic signed [ACC_W-1:0]       acc2_nxt [3];
  logic signed [COORD_WIDTH-1:0] p3_nxt [3];
  logic [SQW-1:0]                sq4_nxt [3];
  logic [SQ_WIDTH-1:0]           sq5_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RESET;
      row_r[1] <= ROW_Y_RESET;
      row_r[2] <= ROW_Z_RESET;
      ref_r    <= REF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_X:     row_r[0] <= cfg_wdata;
        CFG_ROW_Y:     row_r[1] <= cfg_wdata;
        CFG_ROW_Z:     row_r[2] <= cfg_wdata;
        CFG_REF_POINT: ref_r    <= cfg_wdata[REF_WIDTH-1:0];
        default:       ;
      endcase
    end
  end

  assign ref_ext = REFX_W'(ref_r);

  // Credits cover every item in the pipeline or the queue.
  assign in_stall   = (credit_r == CRW'(QUEUE_DEPTH));
  assign in_acc     = in_valid && !in_stall;
  assign credit_nxt = credit_r + CRW'(in_acc) - CRW'(slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign vtx[0] = in_vertex_x;
  assign vtx[1] = in_vertex_y;
  assign vtx[2] = in_vertex_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod1_nxt[j][i] = $signed(row_r[j][COEF_WIDTH*i +: COEF_WIDTH]) * vtx[i];
      end
    end
  end

  // Sum the three products and the scaled translation.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc2_nxt[j] =
        $signed({{(ACC_W-PRW){prod1_r[j][0][PRW-1]}}, prod1_r[j][0]}) +
        $signed({{(ACC_W-PRW){prod1_r[j][1][PRW-1]}}, prod1_r[j][1]}) +
        $signed({{(ACC_W-PRW){prod1_r[j][2][PRW-1]}}, prod1_r[j][2]}) +
        ($signed({{(ACC_W-COEF_WIDTH){trans1_r[j][COEF_WIDTH-1]}}, trans1_r[j]})
          <<< COEF_FRAC);
    end
  end

  // Round half up, then saturate to the coordinate range.
  always_comb begin
    logic signed [ACC_W-1:0] shifted;
    shifted = '0;
    for (int j = 0; j < 3; j++) begin
      shifted = (acc2_r[j] + ROUND_HALF) >>> COEF_FRAC;
      if (shifted > P_HI) begin
        p3_nxt[j] = P_HI[COORD_WIDTH-1:0];
      end else if (shifted < P_LO) begin
        p3_nxt[j] = P_LO[COORD_WIDTH-1:0];
      end else begin
        p3_nxt[j] = shifted[COORD_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    logic signed [DW-1:0]  dlt;
    logic signed [SQW-1:0] sqs;
    logic [COORD_WIDTH-1:0] rc;
    dlt = '0;
    sqs = '0;
    rc  = '0;
    for (int j = 0; j < 3; j++) begin
      rc  = ref_ext[COORD_WIDTH*j +: COORD_WIDTH];
      dlt = $signed({p3_r[j][COORD_WIDTH-1], p3_r[j]}) - $signed({rc[COORD_WIDTH-1], rc});
      sqs = dlt * dlt;
      sq4_nxt[j] = sqs;
    end
  end

  always_comb begin
    logic [SUMW-1:0] total;
    total = SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2]);
    if (total > SUMW'(SQ_MAX)) begin
      sq5_nxt = SQ_MAX;
    end else begin
      sq5_nxt = total[SQ_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod1_r  <= prod1_nxt;
    last1_r  <= in_last_vertex;
    for (int j = 0; j < 3; j++) begin
      trans1_r[j] <= row_r[j][CFG_WIDTH-1 -: COEF_WIDTH];
    end
    acc2_r   <= acc2_nxt;
    last2_r  <= last1_r;
    p3_r     <= p3_nxt;
    last3_r  <= last2_r;
    p4_r     <= p3_r;
    sq4_r    <= sq4_nxt;
    last4_r  <= last3_r;
    for (int j = 0; j < 3; j++) begin
      p5_r[j] <= p4_r[j];
    end
    sq5_r    <= sq5_nxt;
    last5_r  <= last4_r;
  end

  assign push      = v5_r;
  assign push_data = {last5_r, sq5_r, p5_r[2], p5_r[1], p5_r[0]};

endmodule

FILE: rtl/core/tnvs_queue.sv
// Small FIFO between the front pipeline and the minimum tracker.
// Depends on tnvs_pkg for its depth; the front keeps it from overflowing.
module tnvs_queue #(
  parameter int WIDTH = 85
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] q_data
);
  import tnvs_pkg::*;

  logic [WIDTH-1:0]    mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign q_valid   = (count_r != '0);
  assign q_data    = mem_r[rd_ptr_r];
  assign count_nxt = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/core/tnvs_back.sv
// Back end: running minimum of squared distance and the result register.
// Depends on tnvs_pkg for the squared distance width.
module tnvs_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  input  logic [3*COORD_WIDTH+tnvs_pkg::SQ_WIDTH:0] q_data,
  output logic                                     pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [COORD_WIDTH-1:0]            out_closest_x,
  output logic signed [COORD_WIDTH-1:0]            out_closest_y,
  output logic signed [COORD_WIDTH-1:0]            out_closest_z,
  output logic [tnvs_pkg::SQ_WIDTH-1:0]            out_squared_distance
);
  import tnvs_pkg::*;

  localparam int PTW = 3 * COORD_WIDTH;

  logic                have_best_r, have_best_nxt;
  logic [SQ_WIDTH-1:0] best_sq_r, best_sq_nxt;
  logic [PTW-1:0]      best_pt_r, best_pt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SQ_WIDTH-1:0] out_sq_r;
  logic [PTW-1:0]      out_pt_r;

  logic [PTW-1:0]      cand_pt;
  logic [SQ_WIDTH-1:0] cand_sq;
  logic                cand_last;
  logic                take;
  logic                emit;

  assign cand_pt   = q_data[PTW-1:0];
  assign cand_sq   = q_data[PTW +: SQ_WIDTH];
  assign cand_last = q_data[PTW+SQ_WIDTH];

  // A last vertex waits until the result register can take it.
  assign pop  = q_valid && (!cand_last || !out_valid_r || !out_stall);
  assign take = !have_best_r || (cand_sq < best_sq_r);
  assign emit = pop && cand_last;

  always_comb begin
    have_best_nxt = have_best_r;
    best_sq_nxt   = best_sq_r;
    best_pt_nxt   = best_pt_r;
    if (pop && take) begin
      have_best_nxt = 1'b1;
      best_sq_nxt   = cand_sq;
      best_pt_nxt   = cand_pt;
    end
    if (emit) begin
      have_best_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_sq_r <= best_sq_nxt;
    best_pt_r <= best_pt_nxt;
    if (emit) begin
      out_sq_r <= take ? cand_sq : best_sq_r;
      out_pt_r <= take ? cand_pt : best_pt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_closest_x        = out_pt_r[0 +: COORD_WIDTH];
  assign out_closest_y        = out_pt_r[COORD_WIDTH +: COORD_WIDTH];
  assign out_closest_z        = out_pt_r[2*COORD_WIDTH +: COORD_WIDTH];
  assign out_squared_distance = out_sq_r;

endmodule

FILE: rtl/core/transformed_nearest_vertex_search_top.sv
// Transformed nearest vertex search, top level. A vertex passes the front
// registers (products, sum, rounded point, squares, total) and the queue; a
// last vertex then loads the result register from the back end. Throughput:
// one vertex per cycle, set by the compare and update of the running minimum,
// unless a stalled result holds a last vertex; an eight-entry queue decouples
// the front from a stalled result. Reset (synchronous, rst_n low) loads the
// identity transform and origin reference and clears the running minimum.
module transformed_nearest_vertex_search_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tnvs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [tnvs_pkg::CFG_WIDTH-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0]      in_vertex_z,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_closest_x,
  output logic signed [COORD_WIDTH-1:0]      out_closest_y,
  output logic signed [COORD_WIDTH-1:0]      out_closest_z,
  output logic [tnvs_pkg::SQ_WIDTH-1:0]      out_squared_distance
);
  import tnvs_pkg::*;

  // Queue entry: last flag, squared distance, then z, y, x of the point.
  localparam int ENTRY_W = 3 * COORD_WIDTH + SQ_WIDTH + 1;

  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_data;

  // Front: config registers, transform and distance; it stalls the input
  // once every queue slot is spoken for, so the queue never overflows.
  tnvs_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_vertex_z    (in_vertex_z),
    .in_last_vertex (in_last_vertex),
    .slot_free      (pop),
    .push           (push),
    .push_data      (push_data)
  );

  // Hold finished distances until the back end takes them.
  tnvs_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: keep the nearest point (first wins on a tie) and emit on the
  // last vertex through a result register.
  tnvs_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_data               (q_data),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_closest_x        (out_closest_x),
    .out_closest_y        (out_closest_y),
    .out_closest_z        (out_closest_z),
    .out_squared_distance (out_squared_distance)
  );

endmodule

FILE: verif/tb_transformed_nearest_vertex_search_top.sv
// Self-checking testbench for transformed_nearest_vertex_search_top.
// Holds a scoreboard class with its own fixed-point predictor, plus random
// stimulus and back-pressure. Depends on tnvs_pkg and the top-level RTL only.
module tb_transformed_nearest_vertex_search_top;
  import tnvs_pkg::*;

  localparam int CW               = 16;
  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 4;
  localparam int MAX_WAIT         = 19;
  // Front pipeline, back stage and the eight-entry queue, with margin.
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 100;
  localparam int HOLD_PHASE       = 5;
  localparam int HOLD_ITEMS       = 40;
  localparam int TIMEOUT_CYCLES   = 400000;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic [SQ_WIDTH-1:0]   sq;
  } nearest_t;

  // Scoreboard: mirrors the transform, the reference point and the running
  // minimum, and queues one expected nearest point per finished mesh.
  class nearest_vertex_scoreboard;
    logic [CFG_WIDTH-1:0] row [3];
    logic [REF_WIDTH-1:0] ref_point;
    logic [SQ_WIDTH-1:0]  best_sq;
    coord_t               best_pt [3];
    bit                   have_best;
    nearest_t             pending_nearest [$];
    int                   vertices;
    int                   meshes;
    int                   results;
    int                   mismatches;

    function new();
      row[0]     = ROW_X_RESET;
      row[1]     = ROW_Y_RESET;
      row[2]     = ROW_Z_RESET;
      ref_point  = REF_RESET;
      best_sq    = '0;
      best_pt    = '{default: '0};
      have_best  = 1'b0;
      vertices   = 0;
      meshes     = 0;
      results    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
      case (idx)
        CFG_ROW_X:     row[0] = val;
        CFG_ROW_Y:     row[1] = val;
        CFG_ROW_Z:     row[2] = val;
        CFG_REF_POINT: ref_point = val[REF_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // One output coordinate: Q1.14 dot product plus translation, round half up, saturate.
    function coord_t transform_coord(logic [CFG_WIDTH-1:0] r, coord_t vx, coord_t vy,
                                     coord_t vz);
      longint acc;
      acc = longint'($signed(r[0 +: COEF_WIDTH])) * longint'(vx)
          + longint'($signed(r[COEF_WIDTH +: COEF_WIDTH])) * longint'(vy)
          + longint'($signed(r[2*COEF_WIDTH +: COEF_WIDTH])) * longint'(vz);
      acc += longint'($signed(r[3*COEF_WIDTH +: COEF_WIDTH])) <<< COEF_FRAC;
      acc = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
      if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
      return coord_t'(acc);
    endfunction

    function void note_vertex(coord_t vx, coord_t vy, coord_t vz, logic last);
      coord_t   p [3];
      longint   sq;
      longint   d;
      nearest_t res;
      int       i;
      p[0] = transform_coord(row[0], vx, vy, vz);
      p[1] = transform_coord(row[1], vx, vy, vz);
      p[2] = transform_coord(row[2], vx, vy, vz);
      sq = 0;
      for (i = 0; i < 3; i++) begin
        d = longint'(p[i]) - longint'($signed(ref_point[i*CW +: CW]));
        sq += d * d;
      end
      if (sq > longint'(SQ_MAX)) sq = longint'(SQ_MAX);
      vertices++;
      // Strict less-than: on a tie the earlier vertex stays.
      if (!have_best || sq < longint'(best_sq)) begin
        best_sq   = sq[SQ_WIDTH-1:0];
        best_pt   = p;
        have_best = 1'b1;
      end
      if (last) begin
        res.x  = best_pt[0];
        res.y  = best_pt[1];
        res.z  = best_pt[2];
        res.sq = best_sq;
        pending_nearest.push_back(res);
        meshes++;
        best_sq   = '0;
        best_pt   = '{default: '0};
        have_best = 1'b0;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_result(coord_t x, coord_t y, coord_t z, logic [SQ_WIDTH-1:0] sq);
      nearest_t want;
      results++;
      if (pending_nearest.size() == 0) begin
        flag($sformatf("unexpected result %0d: point (%0d,%0d,%0d) sq %0d",
                       results, x, y, z, sq));
        return;
      end
      want = pending_nearest.pop_front();
      if (want.x !== x || want.y !== y || want.z !== z || want.sq !== sq)
        flag($sformatf("result %0d: expected (%0d,%0d,%0d) sq %0d, got (%0d,%0d,%0d) sq %0d",
                       results, want.x, want.y, want.z, want.sq, x, y, z, sq));
    endfunction

    function void close_out();
      if (pending_nearest.size() != 0)
        flag($sformatf("%0d expected results never arrived", pending_nearest.size()));
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  coord_t                   in_vertex_x;
  coord_t                   in_vertex_y;
  coord_t                   in_vertex_z;
  logic                     in_last_vertex;
  logic                     out_valid;
  logic                     out_stall;
  coord_t                   out_closest_x;
  coord_t                   out_closest_y;
  coord_t                   out_closest_z;
  logic [SQ_WIDTH-1:0]      out_squared_distance;

  nearest_vertex_scoreboard sb;

  // Stimulus knobs: tx_quiet for the sender, rx_quiet and rx_hold_req for the receiver.
  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold_req;

  transformed_nearest_vertex_search_top #(
    .COORD_WIDTH(CW)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_vertex_x          (in_vertex_x),
    .in_vertex_y          (in_vertex_y),
    .in_vertex_z          (in_vertex_z),
    .in_last_vertex       (in_last_vertex),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_closest_x        (out_closest_x),
    .out_closest_y        (out_closest_y),
    .out_closest_z        (out_closest_z),
    .out_squared_distance (out_squared_distance)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one vertex after a random gap (none if tx_quiet); hold it until the transfer.
  // Called at a rising edge; in_valid gets a single assignment per step.
  task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t vz,
                             input logic last);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_vertex_x    <= vx;
    in_vertex_y    <= vy;
    in_vertex_z    <= vz;
    in_last_vertex <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_vertex(vx, vy, vz, last);
  endtask

  // Drop valid and wait for every queued result to be transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_nearest.size() != 0) @(posedge clk);
  endtask

  // Drain, then let vertices that produce no result clear the pipeline.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Single-cycle register write; the enable drops on the following edge.
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Random coordinate biased toward the range limits, zero and minus one.
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // Load one register setting per phase; five flavors, each used twice.
  task automatic load_phase(input int p);
    logic [CFG_WIDTH-1:0] r [3];
    logic [CFG_WIDTH-1:0] refw;
    int                   i;
    int                   j;
    int                   c;
    refw = {$urandom(), $urandom()};
    case (p % 5)
      0: begin
        // Identity rotation, random translation.
        r[0] = ROW_X_RESET;
        r[1] = ROW_Y_RESET;
        r[2] = ROW_Z_RESET;
        for (i = 0; i < 3; i++) r[i][3*COEF_WIDTH +: COEF_WIDTH] = 16'($urandom());
      end
      1: begin
        for (i = 0; i < 3; i++) r[i] = {$urandom(), $urandom()};
      end
      2: begin
        // Every coefficient and offset at a signed extreme; heavy saturation.
        for (i = 0; i < 3; i++)
          for (j = 0; j < 4; j++)
            r[i][j*COEF_WIDTH +: COEF_WIDTH] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        refw = $urandom_range(0, 1) ? '1 : {16'($urandom()), 16'h7FFF, 16'h8000, 16'h7FFF};
      end
      3: begin
        // Modest rotation and offsets, so most points stay in range.
        for (i = 0; i < 3; i++) begin
          for (j = 0; j < 3; j++) begin
            c = int'($urandom_range(0, 32768)) - 16384;
            r[i][j*COEF_WIDTH +: COEF_WIDTH] = 16'(c);
          end
          c = int'($urandom_range(0, 8191)) - 4096;
          r[i][3*COEF_WIDTH +: COEF_WIDTH] = 16'(c);
        end
        for (j = 0; j < 3; j++) begin
          c = int'($urandom_range(0, 16383)) - 8192;
          refw[j*CW +: CW] = 16'(c);
        end
      end
      default: begin
        // Zero rotation: every vertex maps to the translation, all ties.
        for (i = 0; i < 3; i++) r[i] = {16'($urandom()), 48'h0};
      end
    endcase
    write_reg(CFG_ROW_X, r[0]);
    write_reg(CFG_ROW_Y, r[1]);
    write_reg(CFG_ROW_Z, r[2]);
    write_reg(CFG_REF_POINT, refw);
    if ($urandom_range(0, 1)) write_reg(CFG_IDX_UNUSED, {$urandom(), $urandom()});
  endtask

  // Receiver: stall a random number of cycles per result while it is offered,
  // plus a long hold-off on request.
  task automatic run_receiver();
    int stall_left;
    int hold_left;
    stall_left = $urandom_range(0, MAX_WAIT);
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_result(out_closest_x, out_closest_y, out_closest_z, out_squared_distance);
        stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (out_valid === 1'b1 && stall_left > 0) begin
        stall_left--;
      end
      if (rx_hold_req) begin
        hold_left   = LONG_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  endtask

  initial begin
    coord_t prev [3];
    coord_t v [3];
    int     p;
    int     n;
    int     mesh_left;
    logic   last;

    sb          = new();
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold_req = 1'b0;

    // Drive every input to a known value before the first edge.
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_ROW_X;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_vertex_x    <= '0;
    in_vertex_y    <= '0;
    in_vertex_z    <= '0;
    in_last_vertex <= 1'b0;

    fork
      run_receiver();
    join_none

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: identity transform, origin reference.
    send_vertex(0, 0, 0, 1'b1);                          // single-vertex mesh
    send_vertex(COORD_MAX, COORD_MIN, 1, 1'b1);
    send_vertex(100, 0, 0, 1'b0);                        // three-way tie
    send_vertex(0, -100, 0, 1'b0);
    send_vertex(0, 0, 100, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);  // largest distance first
    send_vertex(5, 5, 5, 1'b0);
    send_vertex(6, 6, 6, 1'b0);
    send_vertex(5, -5, 5, 1'b1);                         // ties the earlier (5,5,5)
    settle();

    // Directed, extreme settings: half and minus-two coefficients exercise
    // round half up; full-scale rows and offsets saturate both ways.
    write_reg(CFG_ROW_X, 64'h0000_0000_0000_2000);
    write_reg(CFG_ROW_Y, {16'h7FFF, 16'h0000, 16'h8000, 16'h0000});
    write_reg(CFG_ROW_Z, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(CFG_REF_POINT, {16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001});
    send_vertex(1, 1, 1, 1'b0);
    send_vertex(-1, -1, -1, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_vertex(2, -3, 7, 1'b1);
    settle();
    // An unused index must leave all registers alone.
    write_reg(CFG_IDX_UNUSED, '1);
    send_vertex(1, 1, 1, 1'b1);
    send_vertex(-1, 1, -1, 1'b1);
    settle();

    // Random phases: meshes of mostly short length with random content,
    // repeated vertices for ties, and a new register setting per phase.
    prev = '{default: '0};
    for (p = 0; p < PHASES; p++) begin
      load_phase(p);
      rx_quiet  = (p % 4 == 1);
      mesh_left = 0;
      last      = 1'b0;
      if (p == HOLD_PHASE) rx_hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Back-to-back single-vertex meshes fill the queue behind the hold.
        tx_quiet = (p % 3 == 0) || (p == HOLD_PHASE && n < HOLD_ITEMS);
        if (mesh_left == 0) begin
          if (p == HOLD_PHASE && n < HOLD_ITEMS)
            mesh_left = 1;
          else if ($urandom_range(0, 9) == 0)
            mesh_left = $urandom_range(9, 40);
          else
            mesh_left = $urandom_range(1, 8);
        end
        if ($urandom_range(0, 7) == 0) begin
          v = prev;
        end else begin
          v[0] = pick_coord();
          v[1] = pick_coord();
          v[2] = pick_coord();
        end
        last = (mesh_left == 1);
        mesh_left--;
        send_vertex(v[0], v[1], v[2], last);
        prev = v;
        // Pause the sender until every result is back, mid-mesh or not.
        if (n == PHASE_ITEMS / 2 && p % 2 == 0) drain_results();
      end
      // Close an open mesh so the next setting starts from a clear minimum.
      if (!last) send_vertex(pick_coord(), pick_coord(), pick_coord(), 1'b1);
      settle();
    end

    tx_quiet = 1'b0;
    sb.close_out();
    $display("Run covered %0d vertices in %0d meshes over %0d register settings,",
             sb.vertices, sb.meshes, PHASES + 2);
    $display("with saturation, ties, long receiver hold-off; %0d results, %0d mismatches.",
             sb.results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tnvs_pkg.sv
rtl/core/tnvs_front.sv
rtl/core/tnvs_queue.sv
rtl/core/tnvs_back.sv
rtl/core/transformed_nearest_vertex_search_top.sv
verif/tb_transformed_nearest_vertex_search_top.sv
